[src/text_console_character_writer_defines.svh]
// Assertion macros shared by the text console character writer RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef TEXT_CONSOLE_CHARACTER_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHARACTER_WRITER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TCW_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/tcw_pkg.sv]
// Shared types and constants for the text console character writer.
// No dependencies; used by the screen RAM and the top level.
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int ADDR_W  = $clog2(CELLS);
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int WORD_W  = 16;
  localparam int CHAR_W  = 8;
  localparam int MODE_W  = 2;
  localparam int RIDX_W  = 11;
  localparam int TAB_W   = 2;

  localparam logic [CHAR_W-1:0] RESET_ATTR = 8'd7;
  localparam logic [CHAR_W-1:0] CH_NUL     = 8'd0;
  localparam logic [CHAR_W-1:0] CH_BS      = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL      = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_PLACE,
    ST_NEWLINE,
    ST_SCROLL,
    ST_FILL,
    ST_CLEAR,
    ST_READ,
    ST_BS_LAST,
    ST_BS_LCHK,
    ST_BS_RD,
    ST_BS_CHK,
    ST_DONE
  } state_t;

endpackage

[src/tcw_screen_ram.sv]
// Screen cell memory: one write port and one read port with registered data.
// Depends on tcw_pkg for depth and widths.
module tcw_screen_ram
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[src/text_console_character_writer.sv]
// Top level of the text console character writer: command sequencer,
// cursor registers and result register. Depends on tcw_pkg, tcw_screen_ram
// and the assertion macros header.
//
//   channel  direction  handshake                   payload
//   in_      request    in_valid / in_stall         mode, char_code, read_index
//   out_     result     out_valid / out_stall       cursor_column, cursor_line, cell_word
//   cfg_     write      cfg_write_en                text attribute byte
//
// Requests are stalled while a command runs. A tab writes empty cells up to the
// next tab stop. A scroll moves the lines up through the single memory port
// pair and then blanks the bottom line; a clear writes every cell. A backspace
// walk reads and then checks each cell that it examines. After reset a pass
// writes every cell; requests are stalled meanwhile. A stalled result holds;
// the next request is taken while it waits, and that request's result waits
// for the register to free.
`include "text_console_character_writer_defines.svh"

module text_console_character_writer
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_stall,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [RIDX_W-1:0] in_read_index,

  output logic              out_valid,
  input  logic              out_stall,
  output logic [COL_W-1:0]  out_cursor_column,
  output logic [ROW_W-1:0]  out_cursor_line,
  output logic [WORD_W-1:0] out_cell_word,

  input  logic              cfg_write_en,
  input  logic [CHAR_W-1:0] cfg_write_data
);

  localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] COLS_NEG   = ADDR_W'(-COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_ROW_A = ADDR_W'(CELLS - COLUMNS);

  state_t              state_r, state_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [ADDR_W-1:0]   base_r, base_nxt;
  logic [ADDR_W-1:0]   ptr_r, ptr_nxt;
  logic [ADDR_W-1:0]   wr_addr_r, wr_addr_nxt;
  logic                wr_pend_r, wr_pend_nxt;
  logic [CHAR_W-1:0]   attr_r;
  mode_t               mode_r, mode_nxt;
  logic [CHAR_W-1:0]   char_r, char_nxt;
  logic [RIDX_W-1:0]   ridx_r, ridx_nxt;
  logic [CHAR_W-1:0]   place_ch_r, place_ch_nxt;
  logic                tab_r, tab_nxt;
  logic                prev_line_r, prev_line_nxt;
  logic [WORD_W-1:0]   word_r, word_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [COL_W-1:0]    out_col_r, out_col_nxt;
  logic [ROW_W-1:0]    out_row_r, out_row_nxt;
  logic [WORD_W-1:0]   out_word_r, out_word_nxt;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;

  // Shared address adder: cell index, line base steps and scroll source.
  logic [ADDR_W-1:0]   au_a, au_b, au_sum;

  logic [COL_W-1:0]    col_inc, col_dec;
  logic                cell_used;
  logic                in_accept;

  tcw_screen_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign col_inc   = col_r + COL_W'(1);
  assign col_dec   = col_r - COL_W'(1);
  assign cell_used = (ram_rdata[CHAR_W-1:0] != CH_NUL);
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    au_a = base_r;
    au_b = ADDR_W'(col_r);
    case (state_r)
      ST_DECODE:  au_b = COLS_NEG;
      ST_NEWLINE: au_b = COLS_A;
      ST_BS_RD:   au_b = ADDR_W'(col_dec);
      ST_SCROLL: begin
        au_a = ptr_r;
        au_b = COLS_A;
      end
      default:    au_b = ADDR_W'(col_r);
    endcase
  end

  assign au_sum = au_a + au_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      col_r       <= '0;
      row_r       <= '0;
      base_r      <= '0;
      ptr_r       <= '0;
      wr_pend_r   <= 1'b0;
      attr_r      <= RESET_ATTR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      base_r      <= base_nxt;
      ptr_r       <= ptr_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write_en) begin
        attr_r <= cfg_write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r   <= wr_addr_nxt;
    mode_r      <= mode_nxt;
    char_r      <= char_nxt;
    ridx_r      <= ridx_nxt;
    place_ch_r  <= place_ch_nxt;
    tab_r       <= tab_nxt;
    prev_line_r <= prev_line_nxt;
    word_r      <= word_nxt;
    out_col_r   <= out_col_nxt;
    out_row_r   <= out_row_nxt;
    out_word_r  <= out_word_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    base_nxt      = base_r;
    ptr_nxt       = ptr_r;
    wr_addr_nxt   = wr_addr_r;
    wr_pend_nxt   = wr_pend_r;
    mode_nxt      = mode_r;
    char_nxt      = char_r;
    ridx_nxt      = ridx_r;
    place_ch_nxt  = place_ch_r;
    tab_nxt       = tab_r;
    prev_line_nxt = prev_line_r;
    word_nxt      = word_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_waddr     = au_sum;
    ram_wdata     = {attr_r, CH_NUL};
    ram_raddr     = au_sum;

    case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ram_wdata = {RESET_ATTR, CH_NUL};
        if (ptr_r == LAST_CELL) begin
          ptr_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          ptr_nxt = ptr_r + ADDR_W'(1);
        end
      end

      ST_IDLE: begin
        if (in_accept) begin
          mode_nxt  = mode_t'(in_mode);
          char_nxt  = in_char_code;
          ridx_nxt  = in_read_index;
          word_nxt  = '0;
          state_nxt = ST_DECODE;
        end
      end

      ST_DECODE: begin
        case (mode_r)
          MODE_WRITE: begin
            case (char_r)
              CH_NL: state_nxt = ST_NEWLINE;
              CH_CR: begin
                col_nxt   = '0;
                state_nxt = ST_DONE;
              end
              CH_TAB: begin
                place_ch_nxt = CH_SPACE;
                tab_nxt      = 1'b1;
                state_nxt    = ST_PLACE;
              end
              CH_BS: begin
                if (col_r != '0) begin
                  prev_line_nxt = 1'b0;
                  state_nxt     = ST_BS_RD;
                end else if (row_r == '0) begin
                  state_nxt = ST_DONE;
                end else begin
                  // Step up to the last column of the previous line.
                  row_nxt   = row_r - ROW_W'(1);
                  base_nxt  = au_sum;
                  col_nxt   = COL_W'(COLUMNS - 1);
                  state_nxt = ST_BS_LAST;
                end
              end
              default: begin
                place_ch_nxt = char_r;
                tab_nxt      = 1'b0;
                state_nxt    = ST_PLACE;
              end
            endcase
          end
          MODE_CLEAR: begin
            ptr_nxt   = '0;
            state_nxt = ST_CLEAR;
          end
          MODE_READ: begin
            if (32'(ridx_r) < 32'(CELLS)) begin
              ram_raddr = ADDR_W'(ridx_r);
              state_nxt = ST_READ;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          default: state_nxt = ST_DONE;
        endcase
      end

      ST_PLACE: begin
        ram_we    = 1'b1;
        ram_wdata = {attr_r, place_ch_r};
        if (col_inc == COL_W'(COLUMNS)) begin
          state_nxt = ST_NEWLINE;
        end else begin
          col_nxt = col_inc;
          // A tab keeps writing empty cells up to the next tab stop.
          if (tab_r && (col_inc[TAB_W-1:0] != '0)) begin
            place_ch_nxt = CH_NUL;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end

      ST_NEWLINE: begin
        if (row_r == ROW_W'(ROWS - 1)) begin
          ptr_nxt     = '0;
          wr_pend_nxt = 1'b0;
          state_nxt   = ST_SCROLL;
        end else begin
          row_nxt   = row_r + ROW_W'(1);
          col_nxt   = '0;
          base_nxt  = au_sum;
          state_nxt = ST_DONE;
        end
      end

      ST_SCROLL: begin
        // Read one line below while writing the cell read in the previous cycle.
        ram_we    = wr_pend_r;
        ram_waddr = wr_addr_r;
        ram_wdata = ram_rdata;
        if (ptr_r != LAST_ROW_A) begin
          ram_raddr   = au_sum;
          wr_addr_nxt = ptr_r;
          wr_pend_nxt = 1'b1;
          ptr_nxt     = ptr_r + ADDR_W'(1);
        end else begin
          wr_pend_nxt = 1'b0;
          state_nxt   = ST_FILL;
        end
      end

      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        if (ptr_r == LAST_CELL) begin
          col_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          ptr_nxt = ptr_r + ADDR_W'(1);
        end
      end

      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        if (ptr_r == LAST_CELL) begin
          col_nxt   = '0;
          row_nxt   = '0;
          base_nxt  = '0;
          state_nxt = ST_DONE;
        end else begin
          ptr_nxt = ptr_r + ADDR_W'(1);
        end
      end

      ST_READ: begin
        word_nxt  = ram_rdata;
        state_nxt = ST_DONE;
      end

      ST_BS_LAST: begin
        state_nxt = ST_BS_LCHK;
      end

      ST_BS_LCHK: begin
        if (cell_used) begin
          ram_we    = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          prev_line_nxt = 1'b1;
          state_nxt     = ST_BS_RD;
        end
      end

      ST_BS_RD: begin
        if (col_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          col_nxt   = col_dec;
          state_nxt = ST_BS_CHK;
        end
      end

      ST_BS_CHK: begin
        if (cell_used) begin
          // On the previous line the cursor stops right of the last used cell.
          if (prev_line_r) begin
            col_nxt = col_inc;
          end else begin
            ram_we = 1'b1;
          end
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_BS_RD;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_col_nxt   = col_r;
          out_row_nxt   = row_r;
          out_word_nxt  = word_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_cursor_column = out_col_r;
  assign out_cursor_line   = out_row_r;
  assign out_cell_word     = out_word_r;

  `TCW_ASSERT_IMPL(a_cursor_in_range, 1'b1, (32'(col_r) < 32'(COLUMNS)) && (32'(row_r) < 32'(ROWS)), "cursor left the screen")
  `TCW_ASSERT_IMPL(a_base_tracks_row, state_r == ST_IDLE, 32'(base_r) == 32'(row_r) * 32'(COLUMNS), "line base does not match cursor row")
  `TCW_ASSERT_NEXT(a_accept_decodes, in_accept, state_r == ST_DECODE, "accepted request not decoded")
  `TCW_ASSERT_IMPL(a_result_from_done, $rose(out_valid_r), $past(state_r) == ST_DONE, "result loaded outside completion")
  `TCW_ASSERT_IMPL(a_no_write_when_idle, ram_we, (state_r != ST_IDLE) && (state_r != ST_DONE), "screen written while no command runs")

endmodule
